[sv/serial_relay_switch_controller_unit_defines.svh]
// Assertion macros shared by the relay switch controller RTL.
`ifndef SERIAL_RELAY_SWITCH_CONTROLLER_UNIT_DEFINES_SVH
`define SERIAL_RELAY_SWITCH_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define SRSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsc: same-cycle check failed");

// Next-cycle implication, checked while reset is released.
`define SRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsc: next-cycle check failed");

`endif

[sv/srsc_pkg.sv]
// Types and constants of the relay switch controller.
package srsc_pkg;

    localparam int FRAME_BYTES  = 16;
    localparam int LOCK_ENTRIES = 14;
    localparam int SWITCH_COUNT = 8;

    localparam int BYTE_W     = 8;
    localparam int RELAY_W    = 8;
    localparam int MSG_LEN    = 4;
    localparam int POS_W      = $clog2(FRAME_BYTES);
    localparam int MSG_IDX_W  = $clog2(MSG_LEN);
    localparam int RELAY_IDX_W = $clog2(RELAY_W);
    localparam int SW_IDX_W   = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int NUM_W      = 7;

    // Command codes of an input item.
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Frame byte positions.
    localparam int FR_START0 = 0;
    localparam int FR_START1 = 1;
    localparam int FR_MSB    = 2;
    localparam int FR_LSB    = 3;
    localparam int FR_STATE  = 4;
    localparam int FR_LOCK   = 7;
    localparam int FR_FINAL  = 8;
    localparam int FR_END0   = 14;

    // ASCII characters used in frames and messages.
    localparam logic [BYTE_W-1:0] CH_PCT  = 8'h25;
    localparam logic [BYTE_W-1:0] CH_AT   = 8'h40;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CH_E    = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
    localparam logic [BYTE_W-1:0] CH_X    = 8'h58;
    localparam logic [BYTE_W-1:0] CH_L    = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
    localparam logic [BYTE_W-1:0] CH_G    = 8'h47;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] switch_levels;
    } t_item;

    // One finished message: either four bytes to send or a single silent result.
    typedef struct packed {
        logic                          has_tx;
        logic [MSG_LEN-1:0][BYTE_W-1:0] bytes;
        logic [RELAY_W-1:0]            relay;
    } t_msg;

endpackage

[sv/srsc_channels.sv]
// Handshake channel interfaces for input items and result items.
interface srsc_in_if;
    import srsc_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] switch_levels;
    modport source (output valid, command, rx_byte, switch_levels, input ready);
    modport sink   (input valid, command, rx_byte, switch_levels, output ready);
endinterface

interface srsc_out_if;
    import srsc_pkg::*;
    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               last;
    logic [RELAY_W-1:0] relay_bits;
    modport source (output valid, tx_valid, tx_byte, last, relay_bits, input ready);
    modport sink   (input valid, tx_valid, tx_byte, last, relay_bits, output ready);
endinterface

[sv/srsc_in_stage.sv]
// Input register that holds one accepted item until the core takes it.
module srsc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srsc_in_if.sink        i_rx_if,
    input  logic           i_take,
    output logic           o_valid,
    output srsc_pkg::t_item o_item
);
    import srsc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign i_rx_if.ready = !r_valid || i_take;
    assign w_accept      = i_rx_if.valid && i_rx_if.ready;
    assign o_valid       = r_valid;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.command       <= i_rx_if.command;
            r_item.rx_byte       <= i_rx_if.rx_byte;
            r_item.switch_levels <= i_rx_if.switch_levels;
        end
    end

endmodule

[sv/srsc_core.sv]
// Controller state and the single-pass decision logic for frames and switch samples.
module srsc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  srsc_pkg::t_item i_item,
    input  logic            i_res_free,
    output logic            o_take,
    output srsc_pkg::t_msg  o_msg
);
    import srsc_pkg::*;

    logic [BYTE_W-1:0]       r_frame [FRAME_BYTES];
    logic [POS_W-1:0]        r_pos;
    logic [LOCK_ENTRIES-1:0] r_lock;
    logic [SWITCH_COUNT-1:0] r_tracked;
    logic [RELAY_W-1:0]      r_relay;

    logic [POS_W-1:0]        n_pos;
    logic [LOCK_ENTRIES-1:0] n_lock;
    logic [SWITCH_COUNT-1:0] n_tracked;
    logic [RELAY_W-1:0]      n_relay;

    logic [BYTE_W-1:0]       w_msb;
    logic [BYTE_W-1:0]       w_lsb;
    logic [BYTE_W-1:0]       w_state;
    logic                    w_frame_ok;
    logic                    w_digits_ok;
    logic [NUM_W-1:0]        w_num;
    logic [NUM_W-1:0]        w_num_m1;
    logic                    w_num_ok;
    logic [SWITCH_COUNT-1:0] w_hit;
    logic                    w_found;
    logic [SW_IDX_W-1:0]     w_sel;
    logic                    w_level;

    assign o_take = i_valid && i_res_free;

    // Frame fields; the final byte of the frame is the one arriving now.
    assign w_msb   = r_frame[FR_MSB];
    assign w_lsb   = r_frame[FR_LSB];
    assign w_state = r_frame[FR_STATE];
    assign w_frame_ok = (r_frame[FR_START0] == CH_PCT) && (r_frame[FR_START1] == CH_PCT) &&
                        (r_frame[FR_END0] == CH_AT) && (i_item.rx_byte == CH_AT);
    assign w_digits_ok = (w_msb >= CH_ZERO) && (w_msb <= CH_NINE) &&
                         (w_lsb >= CH_ZERO) && (w_lsb <= CH_NINE);
    // Ten times the high digit plus the low digit, as shifts and adds.
    assign w_num = NUM_W'({w_msb[3:0], 3'b000}) + NUM_W'({w_msb[3:0], 1'b0}) +
                   NUM_W'(w_lsb[3:0]);
    assign w_num_m1 = w_num - NUM_W'(1);
    assign w_num_ok = w_digits_ok && (w_num != '0) && (w_num < NUM_W'(LOCK_ENTRIES));

    // Lowest unlocked switch whose level matches its tracked bit.
    always_comb begin
        w_hit = '0;
        w_sel = '0;
        for (int k = 0; k < SWITCH_COUNT; k++) begin
            w_hit[k] = !r_lock[k + 1] && (i_item.switch_levels[k] == r_tracked[k]);
        end
        for (int k = SWITCH_COUNT - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_sel = SW_IDX_W'(k);
            end
        end
    end
    assign w_found = |w_hit;
    assign w_level = i_item.switch_levels[w_sel];

    always_comb begin
        n_pos        = r_pos;
        n_lock       = r_lock;
        n_tracked    = r_tracked;
        n_relay      = r_relay;
        o_msg.has_tx = 1'b0;
        o_msg.bytes  = '0;
        if (i_item.command == CMD_SAMPLE) begin
            if (w_found) begin
                n_relay[RELAY_IDX_W'(w_sel)] = !w_level;
                n_tracked[w_sel]             = !w_level;
                o_msg.has_tx = 1'b1;
                o_msg.bytes  = {CH_ZERO + BYTE_W'(w_sel) + BYTE_W'(1), CH_ZERO,
                                (w_level ? CH_ZERO : CH_ONE), CH_R};
            end
        end else begin
            if ((r_pos == '0) && (i_item.rx_byte != CH_PCT)) begin
                o_msg.has_tx = 1'b1;
                o_msg.bytes  = {CH_X, CH_R, CH_R, CH_E};
            end else if (r_pos == POS_W'(FRAME_BYTES - 1)) begin
                n_pos = '0;
                if (!w_frame_ok) begin
                    o_msg.has_tx = 1'b1;
                    o_msg.bytes  = {CH_S, CH_L, CH_R, CH_E};
                end else if (w_num_ok) begin
                    n_lock[w_num[$clog2(LOCK_ENTRIES)-1:0]] = (r_frame[FR_LOCK] != CH_ZERO);
                    if (w_num <= NUM_W'(SWITCH_COUNT)) begin
                        n_relay[w_num_m1[RELAY_IDX_W-1:0]] = w_state[0];
                    end
                    if (r_frame[FR_FINAL] == CH_ONE) begin
                        o_msg.has_tx = 1'b1;
                        o_msg.bytes  = {w_lsb, w_msb, w_state, CH_G};
                    end
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
        o_msg.relay = n_relay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_lock    <= '0;
            r_tracked <= '1;
            r_relay   <= '0;
        end else if (o_take) begin
            r_pos     <= n_pos;
            r_lock    <= n_lock;
            r_tracked <= n_tracked;
            r_relay   <= n_relay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && (i_item.command == CMD_BYTE)) begin
            r_frame[r_pos] <= i_item.rx_byte;
        end
    end

endmodule

[sv/srsc_tx_serializer.sv]
// Result register that sends a finished message one byte per item.
module srsc_tx_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  srsc_pkg::t_msg i_msg,
    output logic           o_free,
    srsc_out_if.source     o_tx_if
);
    import srsc_pkg::*;

    logic                 r_valid;
    logic [MSG_IDX_W-1:0] r_idx;
    t_msg                 r_msg;
    logic                 w_last;
    logic                 w_fire;

    assign w_last = !r_msg.has_tx || (r_idx == MSG_IDX_W'(MSG_LEN - 1));
    assign w_fire = o_tx_if.valid && o_tx_if.ready;
    assign o_free = !r_valid || (w_fire && w_last);

    assign o_tx_if.valid      = r_valid;
    assign o_tx_if.tx_valid   = r_msg.has_tx;
    assign o_tx_if.tx_byte    = r_msg.has_tx ? r_msg.bytes[r_idx] : '0;
    assign o_tx_if.last       = w_last;
    assign o_tx_if.relay_bits = r_msg.relay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_fire && w_last) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_idx <= r_idx + MSG_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_msg <= i_msg;
        end
    end

endmodule

[sv/serial_relay_switch_controller_unit.sv]
// Top level of the serial relay switch controller.
//
//  Channel   Dir  Port      Payload
//  --------  ---  --------  -----------------------------------------------
//  request   in   i_rx_if   command, rx_byte, switch_levels
//  result    out  o_tx_if   tx_valid, tx_byte, last, relay_bits
//
// An item waits in the input register until the core takes it; one core pass then loads its
// message into the result register, which sends it as one to four result items, one per
// cycle while the result port is ready.
// Reset is synchronous and active low: it clears the frame position, the lock bits and the
// relay drive and sets the tracked levels to all released. A stalled result port holds the
// current message, and the input register keeps taking one more item while a message waits.
`include "serial_relay_switch_controller_unit_defines.svh"

module serial_relay_switch_controller_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srsc_in_if.sink    i_rx_if,
    srsc_out_if.source o_tx_if
);
    import srsc_pkg::*;

    // Item held between the input register and the core.
    logic  w_item_valid;
    t_item w_item;
    // The core takes an item only when the result register is free or drains
    // its last result item in the same cycle.
    logic  w_take;
    logic  w_res_free;
    t_msg  w_msg;

    srsc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx_if (i_rx_if),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    // The core keeps the frame bytes, lock bits, tracked levels and relay
    // drive, and decides the whole message of an item in one pass.
    srsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_item_valid),
        .i_item     (w_item),
        .i_res_free (w_res_free),
        .o_take     (w_take),
        .o_msg      (w_msg)
    );

    srsc_tx_serializer u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take),
        .i_msg   (w_msg),
        .o_free  (w_res_free),
        .o_tx_if (o_tx_if)
    );

    // A message taken by the core shows up on the result port next cycle.
    `SRSC_ASSERT_NEXT(a_take_shows, i_clk, i_rst_n, w_take, o_tx_if.valid)
    // A message that is not finished keeps the result port busy.
    `SRSC_ASSERT_NEXT(a_msg_continues, i_clk, i_rst_n,
        o_tx_if.valid && o_tx_if.ready && !o_tx_if.last, o_tx_if.valid && o_tx_if.tx_valid)
    // An item that sends nothing produces exactly one result item.
    `SRSC_ASSERT_NOW(a_silent_single, i_clk, i_rst_n,
        o_tx_if.valid && !o_tx_if.tx_valid, o_tx_if.last && (o_tx_if.tx_byte == '0))

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the serial relay switch controller, driving both channels.
`timescale 1ns / 100ps

module tb_top;
    import srsc_pkg::*;

    // One result item as it leaves the block.
    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               last;
        logic [RELAY_W-1:0] relay_bits;
    } t_tx_result;

    // Cycles without a handshake on either channel before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off plus a long idle gap on top.
    localparam int HANG_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 270;

    logic i_clk;
    logic i_rst_n;

    srsc_in_if  rx_if ();
    srsc_out_if tx_if ();

    serial_relay_switch_controller_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx_if (rx_if),
        .o_tx_if (tx_if)
    );

    // Shadow copy of the controller state, updated whenever an input item is accepted.
    logic [BYTE_W-1:0]  frame_buf [FRAME_BYTES];
    logic [POS_W-1:0]   frame_pos;
    logic [15:0]        lock_mask;
    logic [7:0]         tracked_lv;
    logic [RELAY_W-1:0] relay_drv;

    // Result items predicted but not yet seen on the output channel, oldest first.
    t_tx_result tx_results_due [$];

    int   error_count;
    int   items_sent;
    int   results_seen;
    int   hold_req;
    bit   full_rate;
    logic [7:0] levels_now;

    always #4 i_clk = ~i_clk;

    // Random idle length: mostly none, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: result %0d: %s", $realtime, results_seen, msg);
        error_count++;
    endtask

    // Works out the result items of one accepted input item and advances the shadow
    // state. Every input yields one to four results; a silent one carries only the
    // relay drive.
    function automatic void predict_tx_results(input logic cmd, input logic [7:0] rx,
                                               input logic [7:0] lv);
        logic [BYTE_W-1:0] msg [MSG_LEN];
        int                cnt;
        int                n;
        int                pos;
        t_tx_result        res;

        cnt = 0;
        if (cmd == CMD_SAMPLE) begin
            // Only the lowest unlocked switch whose level matches its tracked bit is
            // applied; the others are picked up by later samples.
            for (int k = 1; k <= SWITCH_COUNT; k++) begin
                if (lock_mask[k]) continue;
                if (lv[k-1] != tracked_lv[k-1]) continue;
                relay_drv[k-1]  = ~lv[k-1];
                tracked_lv[k-1] = ~lv[k-1];
                msg[0] = CH_R;
                msg[1] = lv[k-1] ? CH_ZERO : CH_ONE;
                msg[2] = CH_ZERO;
                msg[3] = CH_ZERO + 8'(k);
                cnt = MSG_LEN;
                break;
            end
        end else begin
            pos = int'(frame_pos);
            frame_buf[pos] = rx;
            if (pos == 0 && rx != CH_PCT) begin
                // A frame must open with a start byte; anything else is refused.
                msg[0] = CH_E;
                msg[1] = CH_R;
                msg[2] = CH_R;
                msg[3] = CH_X;
                cnt = MSG_LEN;
            end else if (pos == FRAME_BYTES - 1) begin
                frame_pos = '0;
                if (frame_buf[FR_START0] != CH_PCT || frame_buf[FR_START1] != CH_PCT ||
                    frame_buf[FR_END0] != CH_AT || frame_buf[FR_END0+1] != CH_AT) begin
                    msg[0] = CH_E;
                    msg[1] = CH_R;
                    msg[2] = CH_L;
                    msg[3] = CH_S;
                    cnt = MSG_LEN;
                end else if (frame_buf[FR_MSB] >= CH_ZERO && frame_buf[FR_MSB] <= CH_NINE &&
                             frame_buf[FR_LSB] >= CH_ZERO && frame_buf[FR_LSB] <= CH_NINE) begin
                    n = int'(frame_buf[FR_MSB] - CH_ZERO) * 10 +
                        int'(frame_buf[FR_LSB] - CH_ZERO);
                    // Switch numbers outside the lock table drop the whole frame.
                    if (n != 0 && n < LOCK_ENTRIES) begin
                        lock_mask[n] = (frame_buf[FR_LOCK] != CH_ZERO);
                        if (n <= SWITCH_COUNT) begin
                            relay_drv[n-1] = frame_buf[FR_STATE][0];
                        end
                        if (frame_buf[FR_FINAL] == CH_ONE) begin
                            msg[0] = CH_G;
                            msg[1] = frame_buf[FR_STATE];
                            msg[2] = frame_buf[FR_MSB];
                            msg[3] = frame_buf[FR_LSB];
                            cnt = MSG_LEN;
                        end
                    end
                end
            end else begin
                frame_pos = POS_W'(pos + 1);
            end
        end

        if (cnt == 0) begin
            res = '{tx_valid: 1'b0, tx_byte: '0, last: 1'b1, relay_bits: relay_drv};
            tx_results_due.push_back(res);
        end else begin
            for (int i = 0; i < cnt; i++) begin
                res = '{tx_valid: 1'b1, tx_byte: msg[i], last: (i == cnt - 1),
                        relay_bits: relay_drv};
                tx_results_due.push_back(res);
            end
        end
    endfunction

    // Offers one item and waits for the handshake. The caller is always at a rising
    // edge. valid is left high when no gap follows, so the next item goes out back to
    // back without a second assignment in the same step.
    task automatic send_item(input logic cmd, input logic [7:0] rx, input logic [7:0] lv);
        int gap;
        rx_if.valid         <= 1'b1;
        rx_if.command       <= cmd;
        rx_if.rx_byte       <= rx;
        rx_if.switch_levels <= lv;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        predict_tx_results(cmd, rx, lv);
        items_sent++;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends the sixteen bytes of a frame. bad_at picks a delimiter byte to spoil, or
    // -1 for none. With mix set, switch samples are slipped in between frame bytes,
    // which must not disturb the frame position.
    task automatic send_frame(input logic [7:0] msb, input logic [7:0] lsb,
                              input logic [7:0] state_ch, input logic [7:0] lock_ch,
                              input logic [7:0] final_ch, input int bad_at, input bit mix);
        logic [BYTE_W-1:0] fb [FRAME_BYTES];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            fb[i] = 8'($urandom_range(0, 255));
        end
        fb[FR_START0]  = CH_PCT;
        fb[FR_START1]  = CH_PCT;
        fb[FR_MSB]     = msb;
        fb[FR_LSB]     = lsb;
        fb[FR_STATE]   = state_ch;
        fb[FR_LOCK]    = lock_ch;
        fb[FR_FINAL]   = final_ch;
        fb[FR_END0]    = CH_AT;
        fb[FR_END0+1]  = CH_AT;
        if (bad_at >= 0) begin
            fb[bad_at] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (mix && $urandom_range(0, 99) < 8) begin
                random_sample();
            end
            send_item(CMD_BYTE, fb[i], 8'($urandom_range(0, 255)));
        end
    endtask

    // A switch sample: usually one switch changes, sometimes none, sometimes all
    // levels are drawn anew.
    task automatic random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            levels_now = 8'($urandom_range(0, 255));
        end else if (r < 80) begin
            levels_now[$urandom_range(0, SWITCH_COUNT - 1)] ^= 1'b1;
        end
        send_item(CMD_SAMPLE, 8'($urandom_range(0, 255)), levels_now);
    endtask

    // A command frame with random content. The frame position is first brought back
    // to zero with filler bytes, so that the frame lines up with the block's buffer.
    task automatic random_frame();
        int r;
        int n;
        int bad_at;
        logic [7:0] msb, lsb, lock_ch, final_ch;
        while (frame_pos != '0) begin
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n = $urandom_range(1, SWITCH_COUNT);
        end else if (r < 85) begin
            n = $urandom_range(SWITCH_COUNT + 1, LOCK_ENTRIES - 1);
        end else if (r < 90) begin
            n = 0;
        end else begin
            n = $urandom_range(LOCK_ENTRIES, 99);
        end
        msb = CH_ZERO + 8'(n / 10);
        lsb = CH_ZERO + 8'(n % 10);
        // Now and then a digit byte is not a digit at all.
        if (r >= 95) begin
            if ($urandom_range(0, 1)) msb = 8'($urandom_range(0, 255));
            else lsb = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        lock_ch  = (r < 50) ? CH_ZERO : (r < 80) ? CH_ONE : 8'($urandom_range(0, 255));
        final_ch = ($urandom_range(0, 99) < 60) ? CH_ONE : 8'($urandom_range(0, 255));
        // Spoil a delimiter in some frames; byte 0 is spared since that would be a
        // stray start rather than a bad frame.
        r = $urandom_range(0, 99);
        bad_at = (r < 4) ? FR_START1 : (r < 8) ? FR_END0 : (r < 12) ? FR_END0 + 1 : -1;
        send_frame(msb, lsb, 8'($urandom_range(0, 255)), lock_ch, final_ch, bad_at, 1'b1);
    endtask

    // Receiver side. A requested hold-off is counted down here; otherwise ready
    // follows random stalls, or stays high while running at full rate.
    always @(posedge i_clk) begin : drive_ready
        int hold_left;
        int stall_left;
        int g;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!i_rst_n) begin
            tx_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            tx_if.ready <= 1'b0;
            hold_left--;
        end else if (full_rate) begin
            tx_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            tx_if.ready <= 1'b0;
            stall_left--;
        end else begin
            g = pick_gap();
            tx_if.ready <= (g == 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    // Every accepted result is compared with the oldest prediction, field by field.
    always @(posedge i_clk) begin : check_results
        t_tx_result got;
        t_tx_result want;
        if (i_rst_n && tx_if.valid && tx_if.ready) begin
            got = '{tx_valid: tx_if.tx_valid, tx_byte: tx_if.tx_byte, last: tx_if.last,
                    relay_bits: tx_if.relay_bits};
            if (tx_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = tx_results_due.pop_front();
                if (got.tx_valid !== want.tx_valid)
                    report_mismatch($sformatf("tx_valid %b, expected %b",
                                              got.tx_valid, want.tx_valid));
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, expected %h",
                                              got.tx_byte, want.tx_byte));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
                if (got.relay_bits !== want.relay_bits)
                    report_mismatch($sformatf("relay_bits %h, expected %h",
                                              got.relay_bits, want.relay_bits));
            end
            results_seen++;
        end
    end

    // Hang detection: any stretch without a handshake on either channel that outlasts
    // the longest legal pause ends the run.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Coming out of reset every switch reads as released, so each of them reports
    // off once, one per sample, lowest first. A further sample is silent, and an
    // all-pressed sample then turns switch 1 on.
    task automatic test_release_reports();
        levels_now = 8'hFF;
        repeat (SWITCH_COUNT + 1) send_item(CMD_SAMPLE, 8'h00, levels_now);
        levels_now = 8'h00;
        send_item(CMD_SAMPLE, 8'hFF, levels_now);
    endtask

    // Bytes at frame position zero that are not the start byte are refused.
    task automatic test_stray_start();
        send_item(CMD_BYTE, 8'h00, 8'hFF);
        send_item(CMD_BYTE, 8'hFF, 8'h00);
    endtask

    // A good frame for switch 2: relay on, locked, acknowledged. The following sample
    // skips the locked switch and the already pressed switch 1 and turns on switch 3.
    task automatic test_command_frame();
        send_frame(CH_ZERO, CH_ZERO + 8'd2, CH_ONE, CH_ONE, CH_ONE, -1, 1'b0);
        send_item(CMD_SAMPLE, 8'h5A, levels_now);
    endtask

    // Mostly well-formed frames with random content, plus samples and loose bytes
    // that break frames apart.
    task automatic test_random_traffic();
        int r;
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                random_frame();
            end else if (r < 85) begin
                random_sample();
            end else begin
                send_item(CMD_BYTE, ($urandom_range(0, 3) == 0) ? CH_PCT :
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_full_rate();
        full_rate = 1'b1;
        random_frame();
        repeat (8) random_sample();
        random_frame();
        full_rate = 0;
    endtask

    // The receiver holds off for a long stretch while items keep coming back to back,
    // so the block fills up and has to stall its input.
    task automatic test_backpressure();
        hold_req  = HOLD_CYCLES;
        full_rate = 1'b1;
        repeat (6) random_sample();
        random_frame();
        full_rate = 1'b0;
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        rx_if.valid         = 1'b0;
        rx_if.command       = CMD_BYTE;
        rx_if.rx_byte       = '0;
        rx_if.switch_levels = '0;
        frame_pos           = '0;
        lock_mask           = '0;
        tracked_lv          = '1;
        relay_drv           = '0;
        error_count         = 0;
        items_sent          = 0;
        results_seen        = 0;
        hold_req            = 0;
        full_rate           = 1'b0;
        levels_now          = '1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_release_reports();
        test_stray_start();
        test_command_frame();
        test_random_traffic();
        test_full_rate();
        test_backpressure();

        // Stop offering, let every predicted result come out, then give the block a
        // few more cycles to show anything it should not send.
        rx_if.valid <= 1'b0;
        while (tx_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
